// ===== rtl/core/elimination_tree_builder_unit_defines.svh =====
// assertion macros of the elimination tree builder rtl, used by eltb_back
`ifndef ELIMINATION_TREE_BUILDER_UNIT_DEFINES_SVH
`define ELIMINATION_TREE_BUILDER_UNIT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define ETB_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked on every rising clock edge outside reset
`define ETB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/eltb_pkg.sv =====
// shared types and constants of the elimination tree builder
package eltb_pkg;

	localparam int NODE_W        = 10;
	localparam int LINK_W        = NODE_W + 1;
	localparam int DEF_MAX_NODES = 1024;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {NODE_W{1'b0}}};

	typedef struct packed {
		logic [NODE_W-1:0] column;
		logic [NODE_W-1:0] row;
		logic              clear;
		logic              walk;
	} eltb_op_t;

	typedef enum logic [3:0] {
		S_CLR  = 4'b0001,
		S_IDLE = 4'b0010,
		S_READ = 4'b0100,
		S_EVAL = 4'b1000
	} eltb_state_t;

endpackage

// ===== rtl/core/eltb_front.sv =====
// input register and item classification of the elimination tree builder
module eltb_front import eltb_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hold,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [NODE_W-1:0] column,
	input  logic [NODE_W-1:0] row_index,
	input  logic              first_of_column,
	output logic              op_valid,
	output eltb_op_t          op,
	input  logic              op_full
);

	logic              valid_s1;
	logic [NODE_W-1:0] column_s1;
	logic [NODE_W-1:0] row_s1;
	logic              first_s1;
	logic              in_range;
	logic              walk;
	logic              keep;
	logic              drain;
	logic              accept;

	assign in_range = 32'(column_s1) < MAX_NODES;
	assign walk     = row_s1 < column_s1;
	assign keep     = in_range && (first_s1 || walk);
	assign drain    = valid_s1 && (!keep || !op_full);

	assign item_stall = hold || (valid_s1 && !drain);
	assign accept     = item_valid && !item_stall;

	assign op_valid  = valid_s1 && keep;
	assign op.column = column_s1;
	assign op.row    = row_s1;
	assign op.clear  = first_s1;
	assign op.walk   = walk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			column_s1 <= column;
			row_s1    <= row_index;
			first_s1  <= first_of_column;
		end
	end

endmodule

// ===== rtl/core/eltb_queue.sv =====
// short operation queue between classifier and tree walker
module eltb_queue import eltb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  eltb_op_t push_op,
	output logic     full,
	input  logic     pop,
	output logic     pop_valid,
	output eltb_op_t pop_op
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	eltb_op_t        slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_op    = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== rtl/core/eltb_back.sv =====
// ancestor link memory, chain walker and result register
`include "elimination_tree_builder_unit_defines.svh"

module eltb_back import eltb_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  eltb_op_t          op,
	output logic              op_pop,
	output logic              clearing,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [NODE_W-1:0] child,
	output logic [NODE_W-1:0] parent_node
);

	localparam int AW = $clog2(MAX_NODES);

	logic [LINK_W-1:0] link_mem [MAX_NODES];
	logic [LINK_W-1:0] rdata_q;

	eltb_state_t       state_q;
	eltb_state_t       state_d;
	logic [AW-1:0]     clr_cnt_q;
	logic [NODE_W-1:0] col_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] node_d;
	logic              result_valid_q;
	logic [NODE_W-1:0] child_q;
	logic [NODE_W-1:0] parent_q;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [LINK_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic              slot_free;
	logic              emit;

	assign slot_free = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		node_d  = node_q;
		we      = 1'b0;
		waddr   = clr_cnt_q;
		wdata   = LINK_NONE;
		re      = 1'b0;
		raddr   = AW'(node_q);
		op_pop  = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				if (clr_cnt_q == AW'(MAX_NODES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				op_pop = op_valid;
				node_d = op.row;
				if (op_valid && op.clear) begin
					we    = 1'b1;
					waddr = AW'(op.column);
				end
				if (op_valid && op.walk) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				re      = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				we    = 1'b1;
				waddr = AW'(node_q);
				wdata = {1'b0, col_q};
				if (rdata_q[LINK_W-1]) begin
					if (slot_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else if (rdata_q[NODE_W-1:0] < col_q) begin
					re     = 1'b1;
					raddr  = AW'(rdata_q[NODE_W-1:0]);
					node_d = rdata_q[NODE_W-1:0];
				end else begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		if (op_pop) begin
			col_q <= op.column;
		end
		if (emit) begin
			child_q  <= node_q;
			parent_q <= col_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= link_mem[raddr];
		end
	end

	assign clearing     = state_q == S_CLR;
	assign result_valid = result_valid_q;
	assign child        = child_q;
	assign parent_node  = parent_q;

	`ETB_ASSERT_IMPL(a_no_pop_in_clear, state_q == S_CLR, !op_pop,
		"operation taken during clearing pass")
	`ETB_ASSERT_IMPL(a_link_points_up, state_q == S_EVAL && !rdata_q[LINK_W-1],
		rdata_q[NODE_W-1:0] > node_q, "ancestor link does not point upward")
	`ETB_ASSERT_NEXT(a_walker_waits,
		state_q == S_EVAL && rdata_q[LINK_W-1] && result_valid_q && result_stall,
		state_q == S_EVAL && $stable(node_q), "walker left while result slot busy")

endmodule

// ===== rtl/core/elimination_tree_builder_unit.sv =====
// top level of the elimination tree builder
// usage:
//   items enter on item_valid/item_stall with column, row_index and
//   first_of_column; one transaction per nonzero, columns in ascending order
//   results leave on result_valid/result_stall as a child, parent_node pair,
//   at most one per item, only when a walk reaches a chain root
// flow:
//   an item is held in the classifier register, then is queued; items that
//   need no memory work are dropped there at one per cycle outside clearing
//   the walker takes the item (and clears the column link) in S_IDLE, reads the
//   row's link in S_READ, then in S_EVAL points each visited node at the column
//   and reads the next link until a chain root or a link not below the column;
//   it takes no new item until the walk ends, and the result is registered
// reset:
//   after arst_n the ancestor link memory is cleared entry by entry in S_CLR,
//   during which item_stall stays high
// stall:
//   a result holds in the output register while result_stall is high; the
//   walker keeps working and waits only when it has a further result ready
module elimination_tree_builder_unit import eltb_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [NODE_W-1:0] column,
	input  logic [NODE_W-1:0] row_index,
	input  logic              first_of_column,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [NODE_W-1:0] child,
	output logic [NODE_W-1:0] parent_node
);

	logic     clearing;
	logic     push;
	eltb_op_t push_op;
	logic     full;
	logic     pop;
	logic     pop_valid;
	eltb_op_t pop_op;

	eltb_front #(
		.MAX_NODES(MAX_NODES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.hold           (clearing),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.column         (column),
		.row_index      (row_index),
		.first_of_column(first_of_column),
		.op_valid       (push),
		.op             (push_op),
		.op_full        (full)
	);

	eltb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.full     (full),
		.pop      (pop),
		.pop_valid(pop_valid),
		.pop_op   (pop_op)
	);

	eltb_back #(
		.MAX_NODES(MAX_NODES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (pop_valid),
		.op          (pop_op),
		.op_pop      (pop),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.child       (child),
		.parent_node (parent_node)
	);

endmodule

// ===== sim/elimination_tree_builder_checker.sv =====
// checker of the elimination tree builder: tracks ancestor links and compares emitted pairs
`timescale 1ns / 100ps
module elimination_tree_builder_checker import eltb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  logic [NODE_W-1:0] column,
	input  logic [NODE_W-1:0] row_index,
	input  logic              first_of_column,
	input  logic              result_valid,
	input  logic              result_stall,
	input  logic [NODE_W-1:0] child,
	input  logic [NODE_W-1:0] parent_node,
	output int                errors,
	output int                pending
);

	localparam int EDGE_SLOTS = 64;
	localparam int EDGE_AW    = $clog2(EDGE_SLOTS);

	typedef struct packed {
		logic [NODE_W-1:0] child;
		logic [NODE_W-1:0] parent;
	} tree_edge_t;

	logic [LINK_W-1:0] ancestor_of [DEF_MAX_NODES];
	tree_edge_t        expected_edges [EDGE_SLOTS];
	int unsigned       edge_wr;
	int unsigned       edge_rd;

	// walk the compressed chain from the row up to the column
	function automatic void trace_ancestors(input logic [NODE_W-1:0] col,
			input logic [NODE_W-1:0] row, input logic first);
		logic [LINK_W-1:0] node;
		logic [LINK_W-1:0] next_link;
		bit                done;
		done = 1'b0;
		if (first) begin
			ancestor_of[col] = LINK_NONE;
		end
		node = {1'b0, row};
		while (!done && node < {1'b0, col}) begin
			next_link = ancestor_of[node[NODE_W-1:0]];
			ancestor_of[node[NODE_W-1:0]] = {1'b0, col};
			if (next_link == LINK_NONE) begin
				expected_edges[EDGE_AW'(edge_wr)] = '{child: node[NODE_W-1:0], parent: col};
				edge_wr++;
				done = 1'b1;
			end else begin
				node = next_link;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tree_edge_t want;
		if (!arst_n) begin
			for (int k = 0; k < DEF_MAX_NODES; k++) begin
				ancestor_of[k] = LINK_NONE;
			end
			edge_wr = 0;
			edge_rd = 0;
			errors  = 0;
			pending <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				trace_ancestors(column, row_index, first_of_column);
			end
			if (result_valid && !result_stall) begin
				if (edge_wr == edge_rd) begin
					$error("unexpected result transaction: child %0d parent_node %0d",
						child, parent_node);
					errors++;
				end else begin
					want = expected_edges[EDGE_AW'(edge_rd)];
					edge_rd++;
					if (child !== want.child) begin
						$error("child: expected %0d, actual %0d", want.child, child);
						errors++;
					end
					if (parent_node !== want.parent) begin
						$error("parent_node: expected %0d, actual %0d", want.parent,
							parent_node);
						errors++;
					end
				end
			end
			pending <= int'(edge_wr - edge_rd);
		end
	end

endmodule

// ===== sim/tb_elimination_tree_builder_unit.sv =====
// testbench top of the elimination tree builder: stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_elimination_tree_builder_unit import eltb_pkg::*;;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [NODE_W-1:0] column = '0;
	logic [NODE_W-1:0] row_index = '0;
	logic              first_of_column = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] parent_node;
	int                errors;
	int                pending;

	int unsigned       accepted_items = 0;
	bit                calm = 1'b0;
	bit                hold_results = 1'b0;
	bit                drained = 1'b0;

	elimination_tree_builder_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.column          (column),
		.row_index       (row_index),
		.first_of_column (first_of_column),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.child           (child),
		.parent_node     (parent_node)
	);

	elimination_tree_builder_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.column          (column),
		.row_index       (row_index),
		.first_of_column (first_of_column),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.child           (child),
		.parent_node     (parent_node),
		.errors          (errors),
		.pending         (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

	// one nonzero per transaction, with an optional idle burst ahead of it
	task automatic send_nonzero(input logic [NODE_W-1:0] col, input logic [NODE_W-1:0] row,
			input logic first);
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid      <= 1'b1;
		column          <= col;
		row_index       <= row;
		first_of_column <= first;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		accepted_items++;
		if (accepted_items == 300) begin
			hold_results = 1'b1;
		end
		calm = accepted_items >= 860;
	endtask

	// small symmetric pattern, columns ascending, mostly well formed
	task automatic send_matrix();
		int unsigned       size;
		int unsigned       base;
		int unsigned       entries;
		logic [NODE_W-1:0] col;
		logic [NODE_W-1:0] row;
		logic              first;
		size = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 64) : $urandom_range(2, 16);
		base = $urandom_range(0, 1024 - size);
		for (int j = 0; j < size; j++) begin
			col = NODE_W'(base + j);
			entries = $urandom_range(1, 4);
			for (int e = 0; e < entries; e++) begin
				if (j == 0 || $urandom_range(0, 5) == 0) begin
					row = col;
				end else begin
					row = NODE_W'(base + $urandom_range(0, j - 1));
				end
				if ($urandom_range(0, 24) == 0) begin
					row = NODE_W'($urandom_range(0, 1023));
				end
				first = (e == 0) && ($urandom_range(0, 24) != 0);
				send_nonzero(col, row, first);
			end
		end
	endtask

	initial begin
		@(posedge clk);
		forever begin
			if (hold_results && arst_n) begin
				hold_results = 1'b0;
				result_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, out of order columns, repeated first marks, compressed walks
		send_nonzero(10'd0, 10'd0, 1'b1);
		send_nonzero(10'd1023, 10'd1023, 1'b1);
		send_nonzero(10'd1023, 10'd0, 1'b0);
		send_nonzero(10'd1023, 10'd0, 1'b0);
		send_nonzero(10'd0, 10'd1023, 1'b0);
		send_nonzero(10'd5, 10'd900, 1'b1);
		send_nonzero(10'd5, 10'd2, 1'b1);
		send_nonzero(10'd6, 10'd2, 1'b1);
		send_nonzero(10'd6, 10'd3, 1'b0);
		send_nonzero(10'd6, 10'd6, 1'b0);
		send_nonzero(10'd7, 10'd2, 1'b1);
		send_nonzero(10'd7, 10'd3, 1'b0);
		send_nonzero(10'd7, 10'd7, 1'b0);
		send_nonzero(10'd512, 10'd511, 1'b1);
		send_nonzero(10'd1022, 10'd1021, 1'b1);
		send_nonzero(10'd1022, 10'd512, 1'b0);
		send_nonzero(10'd1022, 10'd511, 1'b0);
		send_nonzero(10'd1023, 10'd1022, 1'b1);
		send_nonzero(10'd1023, 10'd0, 1'b0);
		send_nonzero(10'd341, 10'd682, 1'b0);
		send_nonzero(10'd682, 10'd341, 1'b1);

		while (accepted_items < 950) begin
			if (!drained && accepted_items >= 600) begin
				drained = 1'b1;
				item_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(0, 9) == 0) begin
				send_nonzero(NODE_W'($urandom_range(0, 1023)), NODE_W'($urandom_range(0, 1023)),
					1'($urandom_range(0, 1)));
			end else begin
				send_matrix();
			end
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/eltb_pkg.sv
rtl/core/eltb_front.sv
rtl/core/eltb_queue.sv
rtl/core/eltb_back.sv
rtl/core/elimination_tree_builder_unit.sv
sim/elimination_tree_builder_checker.sv
sim/tb_elimination_tree_builder_unit.sv
